// ===== rtl/sliding_window_maximum_defines.svh =====
// Assertion macros for the sliding window maximum checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// check while out of reset
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the sliding window maximum block.
// No dependencies.
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]         win_cfg_t;
  typedef logic [IDX_W-1:0]         tap_idx_t;
  typedef logic [CNT_W-1:0]         fill_cnt_t;

  typedef struct packed {
    logic adv;
    logic start;
  } cell_ctrl_t;

endpackage

// ===== rtl/swm_intf.sv =====
`timescale 1ns / 1ps
// Channel interfaces: sample input, result output and window size write.
// Depends on swm_pkg.
interface swm_in_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  sample;
  logic              start_req;
  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  window_max;
  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
  logic               valid;
  logic               ready;
  swm_pkg::win_cfg_t  window_size;
  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps
// One cell of the maximum chain: holds the maximum over its span of recent samples.
// Depends on swm_pkg.
module swm_cell (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  swm_pkg::sample_t    sample,
  input  swm_pkg::sample_t    prev_max,
  output swm_pkg::sample_t    max_r
);

  swm_pkg::sample_t max_nxt;

  always_comb begin
    if (ctrl.start) begin
      max_nxt = sample;
    end else if (prev_max > sample) begin
      max_nxt = prev_max;
    end else begin
      max_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      max_r <= max_nxt;
    end
  end

endmodule

// ===== rtl/swm_chain.sv =====
`timescale 1ns / 1ps
// Row of swm_cell instances; cell k holds the maximum of the last k+1 samples.
// Depends on swm_pkg and swm_cell.
module swm_chain (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  swm_pkg::sample_t    sample,
  input  swm_pkg::tap_idx_t   tap_sel,
  output swm_pkg::sample_t    tap_max
);

  swm_pkg::sample_t cell_max [swm_pkg::WINDOW_MAX];

  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    swm_pkg::sample_t prev;
    if (i == 0) begin : g_head
      assign prev = sample;
    end else begin : g_body
      assign prev = cell_max[i-1];
    end
    swm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sample   (sample),
      .prev_max (prev),
      .max_r    (cell_max[i])
    );
  end

  assign tap_max = cell_max[tap_sel];

endmodule

// ===== rtl/sliding_window_maximum.sv =====
`timescale 1ns / 1ps
// Sliding window maximum over a stream of signed 32-bit samples.
// Depends on swm_pkg, swm_intf and swm_chain.
//
// in_ch carries one sample per beat; start_req on a beat empties the window
// before that sample is taken in. out_ch gives one window_max beat for each
// input beat once the current sequence holds at least window_size samples,
// and nothing before that. cfg_ch writes window_size (0 acts as 1, values
// above 64 act as 64); write it only while the block is idle.
// Each input beat's result is formed combinationally and registered in
// the output register when the beat is taken. One sample is taken every
// cycle while the output is not stalled: each cell of the chain updates
// its running maximum in a single compare, and the result is a tap select
// plus one compare. Reset clears the sequence and the output valid flag
// and sets window_size to 1. When the receiver stalls with a result held,
// in_ch.ready drops and the result and chain hold until the beat is taken.
module sliding_window_maximum (
  input  logic          clk,
  input  logic          rst_n,
  swm_in_if.sink        in_ch,
  swm_out_if.source     out_ch,
  swm_cfg_if.sink       cfg_ch
);

  swm_pkg::win_cfg_t   win_cfg_r;
  swm_pkg::fill_cnt_t  fill_r;
  swm_pkg::fill_cnt_t  fill_nxt;
  swm_pkg::fill_cnt_t  win_eff;
  logic                out_valid_r;
  swm_pkg::sample_t    out_data_r;
  swm_pkg::sample_t    result;
  swm_pkg::sample_t    tap_max;
  swm_pkg::tap_idx_t   tap_sel;
  swm_pkg::cell_ctrl_t ctrl;
  logic                accept;
  logic                emit;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign accept        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.window_max = out_data_r;

  always_comb begin
    if (win_cfg_r == '0) begin
      win_eff = swm_pkg::fill_cnt_t'(1);
    end else if (win_cfg_r > swm_pkg::win_cfg_t'(swm_pkg::WINDOW_MAX)) begin
      win_eff = swm_pkg::fill_cnt_t'(swm_pkg::WINDOW_MAX);
    end else begin
      win_eff = swm_pkg::fill_cnt_t'(win_cfg_r);
    end
  end

  assign tap_sel    = swm_pkg::tap_idx_t'(win_eff - swm_pkg::fill_cnt_t'(2));
  assign ctrl.adv   = accept;
  assign ctrl.start = in_ch.start_req;

  swm_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .sample  (in_ch.sample),
    .tap_sel (tap_sel),
    .tap_max (tap_max)
  );

  always_comb begin
    if (in_ch.start_req) begin
      fill_nxt = swm_pkg::fill_cnt_t'(1);
    end else if (fill_r == swm_pkg::fill_cnt_t'(swm_pkg::WINDOW_MAX)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + swm_pkg::fill_cnt_t'(1);
    end
  end

  assign emit = fill_nxt >= win_eff;

  always_comb begin
    if (win_eff == swm_pkg::fill_cnt_t'(1)) begin
      result = in_ch.sample;
    end else if (tap_max > in_ch.sample) begin
      result = tap_max;
    end else begin
      result = in_ch.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r   <= swm_pkg::win_cfg_t'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_cfg_r <= cfg_ch.window_size;
      end
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== rtl/swm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for sliding_window_maximum, attached by bind.
// Depends on swm_pkg and sliding_window_maximum_defines.svh.
`include "sliding_window_maximum_defines.svh"

module swm_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::sample_t window_max
);

  `SWM_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out valid after reset")
  `SWM_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(window_max), "stalled beat changed")
  `SWM_ASSERT(a_result_needs_input, $rose(out_valid) |-> $past(in_valid && in_ready), "result without input beat")
  `SWM_ASSERT(a_ready_only_on_stall, !in_ready |-> out_valid && !out_ready, "input blocked without stall")

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .window_max (out_ch.window_max)
);

// ===== bench/sliding_window_maximum_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_maximum: directed table, then random bursts.
// Depends on swm_pkg, swm_intf and the sliding_window_maximum RTL.
module sliding_window_maximum_tb;

  typedef struct packed {
    logic              cfg_set;
    swm_pkg::win_cfg_t cfg;
    swm_pkg::sample_t  smp;
    logic              start;
    logic              typed;
    swm_pkg::sample_t  want;
  } step_t;

  localparam swm_pkg::sample_t S_MIN = 32'sh8000_0000;
  localparam swm_pkg::sample_t S_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();
  swm_cfg_if cfg_ch ();

  sliding_window_maximum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  swm_pkg::sample_t   hist_mem [swm_pkg::WINDOW_MAX];
  swm_pkg::fill_cnt_t hist_fill;
  swm_pkg::tap_idx_t  hist_wr;
  swm_pkg::win_cfg_t  win_len;
  swm_pkg::sample_t   max_due [$];
  int                 err_cnt;
  int                 idle_pct;
  int                 stall_pct;

  step_t dir_tab [20] = '{
    '{1'b0, 7'd0,   S_MAX,          1'b1, 1'b1, S_MAX},
    '{1'b0, 7'd0,   S_MIN,          1'b0, 1'b1, S_MIN},
    '{1'b0, 7'd0,   32'sd0,         1'b0, 1'b1, 32'sd0},
    '{1'b0, 7'd0,   -32'sd1,        1'b0, 1'b1, -32'sd1},
    '{1'b1, 7'd0,   32'sd5,         1'b0, 1'b1, 32'sd5},
    '{1'b1, 7'd2,   S_MIN,          1'b1, 1'b0, 32'sd0},
    '{1'b0, 7'd2,   -32'sd1,        1'b0, 1'b1, -32'sd1},
    '{1'b0, 7'd2,   S_MAX,          1'b0, 1'b1, S_MAX},
    '{1'b0, 7'd2,   S_MIN,          1'b0, 1'b1, S_MAX},
    '{1'b0, 7'd2,   S_MIN,          1'b0, 1'b1, S_MIN},
    '{1'b0, 7'd2,   32'sd3,         1'b1, 1'b0, 32'sd0},
    '{1'b0, 7'd2,   32'sd2,         1'b0, 1'b1, 32'sd3},
    '{1'b1, 7'd3,   32'sd9,         1'b0, 1'b0, 32'sd0},
    '{1'b1, 7'd1,   -32'sd4,        1'b0, 1'b1, -32'sd4},
    '{1'b1, 7'd127, 32'sd1,         1'b1, 1'b0, 32'sd0},
    '{1'b1, 7'd65,  32'sd2,         1'b0, 1'b0, 32'sd0},
    '{1'b1, 7'd64,  32'sd6,         1'b1, 1'b0, 32'sd0},
    '{1'b1, 7'd2,   32'sd7,         1'b0, 1'b1, 32'sd7},
    '{1'b0, 7'd2,   S_MIN,          1'b0, 1'b1, 32'sd7},
    '{1'b1, 7'd1,   32'sd0,         1'b1, 1'b1, 32'sd0}
  };

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // take one sample into the local window copy and work out its maximum
  function automatic void take_sample(input swm_pkg::sample_t smp, input logic start,
                                      output logic hit, output swm_pkg::sample_t peak);
    int                eff;
    int                k;
    swm_pkg::tap_idx_t idx;
    if (start) begin
      hist_fill = '0;
      hist_wr   = '0;
    end
    hist_mem[hist_wr] = smp;
    hist_wr = hist_wr + 1'b1;
    if (hist_fill < swm_pkg::WINDOW_MAX) hist_fill = hist_fill + 1'b1;
    eff = (win_len == 0) ? 1 :
          ((win_len > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : int'(win_len));
    hit  = (hist_fill >= eff);
    peak = smp;
    if (hit) begin
      for (k = 1; k < eff; k++) begin
        idx = swm_pkg::tap_idx_t'(int'(hist_wr) - 1 - k);
        if (hist_mem[idx] > peak) peak = hist_mem[idx];
      end
    end
  endfunction

  task automatic send_beat(input swm_pkg::sample_t smp, input logic start,
                           input logic typed, input swm_pkg::sample_t want);
    logic             hit;
    swm_pkg::sample_t peak;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= smp;
    in_ch.start_req <= start;
    do @(posedge clk); while (!in_ch.ready);
    take_sample(smp, start, hit, peak);
    if (typed) max_due = {max_due, want};
    else if (hit) max_due = {max_due, peak};
  endtask

  // drain, then write the window size
  task automatic set_window(input swm_pkg::win_cfg_t v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (max_due.size() != 0);
    repeat (4) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_len = v;
  endtask

  function automatic swm_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      case ($urandom_range(3))
        0: return S_MIN;
        1: return S_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (r <= 3) return swm_pkg::sample_t'($urandom_range(15)) - 32'sd8;
    return swm_pkg::sample_t'($urandom);
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (max_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected window_max %0d", out_ch.window_max));
      end else begin
        if (out_ch.window_max !== max_due[0])
          flag_mismatch($sformatf("window_max %0d, want %0d", out_ch.window_max, max_due[0]));
        void'(max_due.pop_front());
      end
    end
  end

  initial begin
    int                ph;
    int                sent;
    int                len;
    int                j;
    int                w;
    swm_pkg::win_cfg_t v;
    logic              st;
    err_cnt   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    hist_fill = '0;
    hist_wr   = '0;
    win_len   = 7'd1;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.start_req    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.window_size <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_set) set_window(dir_tab[i].cfg);
      send_beat(dir_tab[i].smp, dir_tab[i].start, dir_tab[i].typed, dir_tab[i].want);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < 185) begin
        case ($urandom_range(9))
          0: v = 7'd64;
          1: v = ($urandom_range(1) != 0) ? 7'd127 : 7'd65;
          2: v = 7'd0;
          3: v = swm_pkg::win_cfg_t'($urandom_range(127));
          default: v = swm_pkg::win_cfg_t'($urandom_range(1, 8));
        endcase
        set_window(v);
        w = (v == 0) ? 1 :
            ((v > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : int'(v));
        len = (w > 8) ? $urandom_range(w, w + 24) : $urandom_range(1, 3 * w + 10);
        for (j = 0; j < len; j++) begin
          if (j == 0) st = ($urandom_range(99) < 85);
          else st = ($urandom_range(99) < 3);
          send_beat(pick_sample(), st, 1'b0, '0);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (max_due.size() != 0);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
